FILE: rtl/ppid_pkg.sv
// Constants and types for the position PID controller with angle wrap.
`default_nettype none

package ppid_pkg;

  // Angle wrap: an error beyond plus or minus a half turn is shifted once by a full turn.
  localparam bit WRAP_ENABLE     = 1'b1;
  localparam int HALF_TURN       = 1800;
  localparam int MIN_INTERVAL_MS = 20;

  // Derivative scale, tenths of a degree per millisecond to per second.
  localparam int DERIV_SCALE = 1000;

  // Error width after wrap and dividend width of the derivative divider.
  localparam int ERR_W = 18;
  localparam int DIV_W = 27;
  localparam int CNT_W = $clog2(DIV_W);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_UPDATE     = 2'd0,
    CMD_ACTIVATE   = 2'd1,
    CMD_DEACTIVATE = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET_MIN   = 3'd3,
    REG_TARGET_MAX   = 3'd4,
    REG_DRIVE_MIN    = 3'd5,
    REG_DRIVE_MAX    = 3'd6,
    REG_WINDUP_LIMIT = 3'd7
  } reg_idx_e;

  localparam logic signed [15:0] TARGET_MIN_RST = 16'sh8000;
  localparam logic signed [15:0] TARGET_MAX_RST = 16'sh7FFF;
  localparam logic signed [15:0] DRIVE_MIN_RST  = 16'sh8000;
  localparam logic signed [15:0] DRIVE_MAX_RST  = 16'sh7FFF;
  localparam logic [30:0]        WINDUP_RST     = 31'd1000000;

endpackage

`default_nettype wire

FILE: rtl/position_pid_with_angle_wrap_core.sv
// Position PID controller with angle wrap, one shared multiplier and a serial divider.
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | cmd, now_ms, target_angle, measured_angle
//  out     | source    | speed_command, recomputed, running
//  cfg     | sink      | register index (3 bits), write data (32 bits)
//
// A recomputing update occupies the datapath through multiplier steps and control
// plus the restoring divider that forms the derivative, one quotient bit per cycle.
// A new item is taken only while the sequencer is idle; a result may wait in the
// output register while the next item is accepted.
// Reset is asynchronous, active low, and loads the register reset values.
`default_nettype none

module position_pid_with_angle_wrap_core
  import ppid_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [31:0]          now_ms_i,
  input  wire logic signed [15:0]   target_angle_i,
  input  wire logic signed [15:0]   measured_angle_i,

  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic signed [15:0]   speed_command_o,
  output      logic                 recomputed_o,
  output      logic                 running_o,

  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_MINT, ST_ACC, ST_DSET, ST_DIV, ST_DRV,
    ST_MP, ST_MI, ST_MD, ST_SUM, ST_FIN, ST_DONE
  } state_e;

  localparam logic signed [ERR_W-1:0] HalfTurnE = ERR_W'(HALF_TURN);
  localparam logic signed [ERR_W-1:0] FullTurnE = ERR_W'(2 * HALF_TURN);
  localparam logic [31:0]             MinGap    = 32'(MIN_INTERVAL_MS);
  localparam logic signed [32:0]      DerivK    = 33'(DERIV_SCALE);
  localparam logic [CNT_W-1:0]        DivLast   = CNT_W'(DIV_W - 1);

  state_e state_q;

  // Configuration registers.
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [15:0] target_min_q, target_max_q, drive_min_q, drive_max_q;
  logic [30:0]        windup_q;

  // Controller state.
  logic                    enabled_q;
  logic [31:0]             last_stamp_q;
  logic signed [ERR_W-1:0] prev_err_q;
  logic signed [31:0]      err_sum_q;
  logic signed [15:0]      held_q;

  // Working registers of one update.
  logic [31:0]             dt_q;
  logic signed [15:0]      tgt_q, meas_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      sum_q;
  logic [DIV_W-1:0]        dvd_q;
  logic [31:0]             rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    neg_q;
  logic signed [DIV_W:0]   deriv_q;

  // Result waiting for the output register, and the output register itself.
  logic signed [15:0] res_speed_q;
  logic               res_fresh_q, res_run_q;
  logic               out_valid_q;
  logic signed [15:0] out_speed_q;
  logic               out_fresh_q, out_run_q;

  logic [31:0]             dt_w;
  logic signed [15:0]      tgt_c;
  logic signed [ERR_W-1:0] err_raw, err_w;
  logic signed [ERR_W:0]   diff_w;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      mul_p;
  logic signed [63:0]      acc_w, wl_w, nwl_w;
  logic signed [31:0]      clamp_w;
  logic [32:0]             trial_w;
  logic                    qbit_w;
  logic [31:0]             rem_w;
  logic signed [63:0]      drv_hi_w, drv_lo_w, round_w;
  logic signed [63:0]      mag_w;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign speed_command_o = out_speed_q;
  assign recomputed_o    = out_fresh_q;
  assign running_o       = out_run_q;

  assign dt_w = now_ms_i - last_stamp_q;

  // Setpoint clamp, error, and one full-turn shift of an error beyond plus or minus a half turn.
  always_comb begin
    priority if (tgt_q > target_max_q) begin
      tgt_c = target_max_q;
    end else if (tgt_q < target_min_q) begin
      tgt_c = target_min_q;
    end else begin
      tgt_c = tgt_q;
    end
    err_raw = ERR_W'(tgt_c) - ERR_W'(meas_q);
    err_w   = err_raw;
    if (WRAP_ENABLE) begin
      priority if (err_raw > HalfTurnE) begin
        err_w = err_raw - FullTurnE;
      end else if (err_raw < -HalfTurnE) begin
        err_w = err_raw + FullTurnE;
      end
    end
  end

  assign diff_w = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_err_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MINT: begin
        mul_a = 33'(err_q);
        mul_b = {1'b0, dt_q};
      end
      ST_ACC: begin
        mul_a = 33'(diff_w);
        mul_b = DerivK;
      end
      ST_MP: begin
        mul_a = 33'(gain_p_q);
        mul_b = 33'(err_q);
      end
      ST_MI: begin
        mul_a = 33'(gain_i_q);
        mul_b = 33'(err_sum_q);
      end
      ST_MD: begin
        mul_a = 33'(gain_d_q);
        mul_b = 33'(deriv_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral clamp against the symmetric windup limit.
  always_comb begin
    acc_w = 64'(err_sum_q) + prod_q;
    wl_w  = {33'd0, windup_q};
    nwl_w = -wl_w;
    priority if (acc_w > wl_w) begin
      clamp_w = wl_w[31:0];
    end else if (acc_w < nwl_w) begin
      clamp_w = nwl_w[31:0];
    end else begin
      clamp_w = acc_w[31:0];
    end
  end

  assign mag_w = prod_q[63] ? -prod_q : prod_q;

  // One restoring division step on the derivative magnitude.
  always_comb begin
    trial_w = {rem_q, dvd_q[DIV_W-1]};
    qbit_w  = (trial_w >= {1'b0, dt_q});
    rem_w   = qbit_w ? 32'(trial_w - {1'b0, dt_q}) : trial_w[31:0];
  end

  assign drv_hi_w = {{32{drive_max_q[15]}}, drive_max_q, 16'd0};
  assign drv_lo_w = {{32{drive_min_q[15]}}, drive_min_q, 16'd0};
  assign round_w  = sum_q + 64'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      target_min_q <= TARGET_MIN_RST;
      target_max_q <= TARGET_MAX_RST;
      drive_min_q  <= DRIVE_MIN_RST;
      drive_max_q  <= DRIVE_MAX_RST;
      windup_q     <= WINDUP_RST;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GAIN_P:       gain_p_q     <= cfg_data_i;
        REG_GAIN_I:       gain_i_q     <= cfg_data_i;
        REG_GAIN_D:       gain_d_q     <= cfg_data_i;
        REG_TARGET_MIN:   target_min_q <= cfg_data_i[15:0];
        REG_TARGET_MAX:   target_max_q <= cfg_data_i[15:0];
        REG_DRIVE_MIN:    drive_min_q  <= cfg_data_i[15:0];
        REG_DRIVE_MAX:    drive_max_q  <= cfg_data_i[15:0];
        REG_WINDUP_LIMIT: windup_q     <= cfg_data_i[30:0];
      endcase
    end
  end

  // Payload working registers need no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];
    if (in_valid_i && in_ready_o) begin
      dt_q   <= dt_w;
      tgt_q  <= target_angle_i;
      meas_q <= measured_angle_i;
    end
    unique case (state_q)
      ST_ERR: err_q <= err_w;
      ST_DSET: begin
        neg_q <= prod_q[63];
        dvd_q <= mag_w[DIV_W-1:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_w;
        dvd_q <= {dvd_q[DIV_W-2:0], qbit_w};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_DRV:  deriv_q <= neg_q ? -{1'b0, dvd_q} : {1'b0, dvd_q};
      ST_MI:   sum_q   <= prod_q;
      ST_MD:   sum_q   <= sum_q + prod_q;
      ST_SUM:  sum_q   <= sum_q + prod_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enabled_q    <= 1'b0;
      last_stamp_q <= '0;
      prev_err_q   <= '0;
      err_sum_q    <= '0;
      held_q       <= '0;
      res_speed_q  <= '0;
      res_fresh_q  <= 1'b0;
      res_run_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_fresh_q  <= 1'b0;
      out_run_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            res_speed_q <= '0;
            res_fresh_q <= 1'b0;
            state_q     <= ST_DONE;
            unique case (cmd_e'(cmd_i))
              CMD_ACTIVATE: begin
                enabled_q    <= 1'b1;
                prev_err_q   <= '0;
                err_sum_q    <= '0;
                held_q       <= '0;
                last_stamp_q <= now_ms_i;
                res_run_q    <= 1'b1;
              end
              CMD_DEACTIVATE: begin
                enabled_q <= 1'b0;
                held_q    <= '0;
                res_run_q <= 1'b0;
              end
              CMD_CLEAR: begin
                prev_err_q   <= '0;
                err_sum_q    <= '0;
                held_q       <= '0;
                last_stamp_q <= now_ms_i;
                res_run_q    <= enabled_q;
              end
              CMD_UPDATE: begin
                res_run_q <= enabled_q;
                if (enabled_q) begin
                  if (dt_w < MinGap) begin
                    res_speed_q <= held_q;
                  end else begin
                    last_stamp_q <= now_ms_i;
                    state_q      <= ST_ERR;
                  end
                end
              end
            endcase
          end
        end
        ST_ERR:  state_q <= ST_MINT;
        ST_MINT: state_q <= ST_ACC;
        ST_ACC: begin
          err_sum_q <= clamp_w;
          state_q   <= ST_DSET;
        end
        ST_DSET: state_q <= ST_DIV;
        ST_DIV: begin
          if (cnt_q == DivLast) begin
            state_q <= ST_DRV;
          end
        end
        ST_DRV: state_q <= ST_MP;
        ST_MP:  state_q <= ST_MI;
        ST_MI:  state_q <= ST_MD;
        ST_MD:  state_q <= ST_SUM;
        ST_SUM: state_q <= ST_FIN;
        ST_FIN: begin
          // Limits are tested high first, so crossed limits still give a limit.
          priority if (sum_q > drv_hi_w) begin
            held_q      <= drive_max_q;
            res_speed_q <= drive_max_q;
          end else if (sum_q < drv_lo_w) begin
            held_q      <= drive_min_q;
            res_speed_q <= drive_min_q;
          end else begin
            held_q      <= round_w[31:16];
            res_speed_q <= round_w[31:16];
          end
          prev_err_q  <= err_q;
          res_fresh_q <= 1'b1;
          res_run_q   <= 1'b1;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_speed_q <= res_speed_q;
            out_fresh_q <= res_fresh_q;
            out_run_q   <= res_run_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the position PID controller with angle wrap.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 65;

  // Reset values of the limit registers as full write words.
  localparam logic [31:0] TGT_MIN_WORD = 32'(TARGET_MIN_RST);
  localparam logic [31:0] TGT_MAX_WORD = 32'(TARGET_MAX_RST);
  localparam logic [31:0] DRV_MIN_WORD = 32'(DRIVE_MIN_RST);
  localparam logic [31:0] DRV_MAX_WORD = 32'(DRIVE_MAX_RST);
  localparam logic [31:0] WINDUP_WORD  = 32'(WINDUP_RST);

  typedef struct packed {
    logic signed [15:0] speed;
    logic               recomputed;
    logic               running;
  } drive_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_cmd = CMD_UPDATE;
  logic [31:0]             in_now = '0;
  logic signed [15:0]      in_target = '0;
  logic signed [15:0]      in_measured = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [15:0]      out_speed;
  logic                    out_recomputed;
  logic                    out_running;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_GAIN_P;
  logic [31:0]             cfg_data = '0;

  always #4ns clk = ~clk;

  position_pid_with_angle_wrap_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (in_cmd),
    .now_ms_i         (in_now),
    .target_angle_i   (in_target),
    .measured_angle_i (in_measured),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .speed_command_o  (out_speed),
    .recomputed_o     (out_recomputed),
    .running_o        (out_running),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Controller state as the predictor sees it.
  logic                    pid_on = 1'b0;
  logic [31:0]             last_ms = '0;
  logic signed [ERR_W-1:0] prev_err = '0;
  logic signed [31:0]      err_integral = '0;
  logic signed [15:0]      held_cmd = '0;

  // Register copies.
  logic signed [31:0]      kp = '0;
  logic signed [31:0]      ki = '0;
  logic signed [31:0]      kd = '0;
  logic signed [15:0]      tgt_lo = TARGET_MIN_RST;
  logic signed [15:0]      tgt_hi = TARGET_MAX_RST;
  logic signed [15:0]      drv_lo = DRIVE_MIN_RST;
  logic signed [15:0]      drv_hi = DRIVE_MAX_RST;
  logic [30:0]             windup = WINDUP_RST;

  drive_result_t           speed_results_q[$];

  int                      error_count = 0;
  int                      cycle_count = 0;
  int                      items_accepted = 0;
  int                      results_checked = 0;
  int                      recompute_count = 0;
  int                      cfg_writes = 0;
  int                      settings_used = 0;

  int                      burst_left = 0;
  int                      gap_max = 3;
  logic [31:0]             stamp_ms = '0;

  logic [15:0]             ready_pattern = 16'hFFFF;
  int                      pattern_pos = 0;
  int                      hold_req = 0;
  int                      hold_left = 0;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void wipe_history(input logic [31:0] now);
    prev_err = '0;
    err_integral = '0;
    held_cmd = '0;
    last_ms = now;
  endfunction

  function automatic drive_result_t pid_step(input cmd_e op, input logic [31:0] now,
                                             input logic signed [15:0] tgt_in,
                                             input logic signed [15:0] meas_in);
    drive_result_t r;
    logic [31:0]   dt;
    longint        dt_l, tgt, err, acc, lim, deriv, sum, hi, lo;
    r = '0;
    dt = now - last_ms;
    dt_l = longint'(dt);
    case (op)
      CMD_ACTIVATE: begin
        pid_on = 1'b1;
        wipe_history(now);
      end
      CMD_DEACTIVATE: begin
        pid_on = 1'b0;
        held_cmd = '0;
      end
      CMD_CLEAR: wipe_history(now);
      default: begin
        if (pid_on && dt >= MIN_INTERVAL_MS) begin
          last_ms = now;
          tgt = longint'(tgt_in);
          // Upper limit is tested first, which matters when the limits cross.
          if (tgt > tgt_hi) tgt = longint'(tgt_hi);
          else if (tgt < tgt_lo) tgt = longint'(tgt_lo);
          err = tgt - longint'(meas_in);
          if (WRAP_ENABLE) begin
            if (err > HALF_TURN) err -= 2 * HALF_TURN;
            else if (err < -HALF_TURN) err += 2 * HALF_TURN;
          end
          lim = longint'(windup);
          acc = longint'(err_integral) + err * dt_l;
          if (acc > lim) acc = lim;
          else if (acc < -lim) acc = -lim;
          err_integral = 32'(acc);
          deriv = ((err - longint'(prev_err)) * DERIV_SCALE) / dt_l;
          sum = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * deriv;
          hi = longint'(drv_hi) * 65536;
          lo = longint'(drv_lo) * 65536;
          if (sum > hi) held_cmd = drv_hi;
          else if (sum < lo) held_cmd = drv_lo;
          else held_cmd = 16'((sum + 32768) >>> 16);
          prev_err = ERR_W'(err);
          r.recomputed = 1'b1;
        end
        if (pid_on) r.speed = held_cmd;
      end
    endcase
    r.running = pid_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      speed_results_q.push_back(pid_step(cmd_e'(in_cmd), in_now, in_target, in_measured));
      items_accepted++;
    end
  end

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (out_valid && out_ready) begin
      results_checked++;
      if (speed_results_q.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b/%0b with nothing expected",
                                  out_speed, out_recomputed, out_running));
      end else begin
        want = speed_results_q.pop_front();
        if (want.recomputed) recompute_count++;
        if (out_speed !== want.speed)
          report_mismatch($sformatf("speed_command %0d, expected %0d", out_speed, want.speed));
        if (out_recomputed !== want.recomputed)
          report_mismatch($sformatf("recomputed %0b, expected %0b",
                                    out_recomputed, want.recomputed));
        if (out_running !== want.running)
          report_mismatch($sformatf("running %0b, expected %0b", out_running, want.running));
      end
    end
  end

  // Receiver: a rotating stall pattern, replaced now and then, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pattern[pattern_pos];
      pattern_pos = (pattern_pos + 1) % 16;
      if (pattern_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hFFFF;
          1, 2: ready_pattern = 16'($urandom);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, speed_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one beat; the time stamp advances by step ms. Valid stays high between
  // beats of a burst and drops only for a gap.
  task automatic send_beat(input cmd_e op, input int unsigned step,
                           input logic signed [15:0] tgt, input logic signed [15:0] meas);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    stamp_ms += step;
    in_valid <= 1'b1;
    in_cmd <= op;
    in_now <= stamp_ms;
    in_target <= tgt;
    in_measured <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (speed_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIN_P:       kp = data;
      REG_GAIN_I:       ki = data;
      REG_GAIN_D:       kd = data;
      REG_TARGET_MIN:   tgt_lo = data[15:0];
      REG_TARGET_MAX:   tgt_hi = data[15:0];
      REG_DRIVE_MIN:    drv_lo = data[15:0];
      REG_DRIVE_MAX:    drv_hi = data[15:0];
      REG_WINDUP_LIMIT: windup = data[30:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic program_all(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                             input logic [31:0] t_lo, input logic [31:0] t_hi,
                             input logic [31:0] d_lo, input logic [31:0] d_hi,
                             input logic [31:0] w);
    wait_results_drained();
    cfg_write(REG_GAIN_P, p);
    cfg_write(REG_GAIN_I, i);
    cfg_write(REG_GAIN_D, d);
    cfg_write(REG_TARGET_MIN, t_lo);
    cfg_write(REG_TARGET_MAX, t_hi);
    cfg_write(REG_DRIVE_MIN, d_lo);
    cfg_write(REG_DRIVE_MAX, d_hi);
    cfg_write(REG_WINDUP_LIMIT, w);
    settings_used++;
  endtask

  // Uniform value in [-2^k, 2^k] as a 32-bit pattern.
  function automatic logic [31:0] rand_span(input int k);
    return $urandom_range(0, 2 << k) - (32'd1 << k);
  endfunction

  task automatic random_item();
    cmd_e               op;
    int unsigned        step;
    logic signed [15:0] tgt, meas;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (!pid_on && pick < 60) op = CMD_ACTIVATE;
    else if (pick < 3) op = CMD_DEACTIVATE;
    else if (pick < 8) op = CMD_CLEAR;
    else if (pick < 10) op = CMD_ACTIVATE;
    else op = CMD_UPDATE;
    case ($urandom_range(0, 19))
      0, 1: step = $urandom_range(0, MIN_INTERVAL_MS - 1);
      2: step = MIN_INTERVAL_MS;
      3: step = $urandom_range(1000, 1 << 20);
      4: step = $urandom;
      default: step = $urandom_range(MIN_INTERVAL_MS, 150);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        tgt = 16'($urandom);
        meas = 16'($urandom);
      end
      3: begin
        tgt = ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000) ^ 16'($urandom_range(0, 3));
        meas = ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000) ^ 16'($urandom_range(0, 3));
      end
      default: begin
        // Target and feedback close together, often across the wrap point.
        tgt = 16'(int'($urandom_range(0, 6000)) - 3000);
        meas = 16'(int'(tgt) - (int'($urandom_range(0, 8000)) - 4000));
      end
    endcase
    send_beat(op, step, tgt, meas);
  endtask

  task automatic test_inactive_commands();
    gap_max = 2;
    stamp_ms = 32'hFFFF_FFD0;
    send_beat(CMD_UPDATE, 0, 16'sd100, 16'sd0);
    send_beat(CMD_DEACTIVATE, 5, 16'sd0, 16'sd0);
    send_beat(CMD_CLEAR, 5, 16'sd0, 16'sd0);
    send_beat(CMD_ACTIVATE, 5, 16'sd0, 16'sd0);
    send_beat(CMD_UPDATE, MIN_INTERVAL_MS - 1, 16'sd50, 16'sd0);
  endtask

  // Time stamps cross the 32-bit wrap here.
  task automatic test_update_timing_and_wrap();
    program_all(32'h0001_0000, 32'd1, 32'd16, TGT_MIN_WORD, TGT_MAX_WORD,
                DRV_MIN_WORD, DRV_MAX_WORD, WINDUP_WORD);
    send_beat(CMD_UPDATE, 20, 16'sd100, 16'sd0);
    send_beat(CMD_UPDATE, 20, 16'sd1800, 16'sd0);
    send_beat(CMD_UPDATE, 20, -16'sd32768, 16'sd32767);
    send_beat(CMD_UPDATE, 25, 16'sd32767, -16'sd32768);
    send_beat(CMD_UPDATE, 20, 16'sd1801, 16'sd0);
    send_beat(CMD_UPDATE, 20, -16'sd1801, 16'sd0);
    send_beat(CMD_CLEAR, 3, 16'sd0, 16'sd0);
    send_beat(CMD_UPDATE, 5, 16'sd10, 16'sd0);
    send_beat(CMD_UPDATE, 15, 16'sd10, 16'sd0);
    send_beat(CMD_DEACTIVATE, 20, 16'sd0, 16'sd0);
    send_beat(CMD_UPDATE, 30, 16'sd0, 16'sd0);
  endtask

  task automatic test_crossed_limits();
    program_all(32'h0001_0000, 32'd0, 32'd0, 32'd500, -32'sd500, 32'd100, -32'sd100, WINDUP_WORD);
    send_beat(CMD_ACTIVATE, 1, 16'sd0, 16'sd0);
    send_beat(CMD_UPDATE, 20, 16'sd1000, 16'sd0);
    send_beat(CMD_UPDATE, 20, -16'sd1000, 16'sd0);
    send_beat(CMD_UPDATE, 20, 16'sd0, 16'sd0);
  endtask

  task automatic test_rounding_and_gain_extremes();
    // Half gain with the integral held at zero: odd errors land on halves.
    program_all(32'h0000_8000, 32'd0, 32'd0, TGT_MIN_WORD, TGT_MAX_WORD,
                DRV_MIN_WORD, DRV_MAX_WORD, 32'd0);
    send_beat(CMD_ACTIVATE, 1, 16'sd0, 16'sd0);
    send_beat(CMD_UPDATE, 20, 16'sd1, 16'sd0);
    send_beat(CMD_UPDATE, 20, -16'sd1, 16'sd0);
    send_beat(CMD_UPDATE, 20, 16'sd3, 16'sd0);
    send_beat(CMD_UPDATE, 20, -16'sd3, 16'sd0);
    program_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, TGT_MIN_WORD, TGT_MAX_WORD,
                DRV_MIN_WORD, DRV_MAX_WORD, 32'hFFFF_FFFF);
    send_beat(CMD_UPDATE, 20, 16'sd32767, 16'sd0);
    send_beat(CMD_UPDATE, 1000, -16'sd32768, 16'sd0);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          program_all(rand_span(18), rand_span(8), rand_span(12), TGT_MIN_WORD,
                      TGT_MAX_WORD, DRV_MIN_WORD, DRV_MAX_WORD, WINDUP_WORD);
          gap_max = 4;
        end
        1: begin
          program_all(rand_span(18), rand_span(8), rand_span(12), $urandom, $urandom,
                      rand_span(11), rand_span(11), $urandom_range(0, 200000));
          gap_max = 0;
        end
        2: begin
          program_all($urandom, $urandom, $urandom, TGT_MIN_WORD, TGT_MAX_WORD,
                      DRV_MIN_WORD, DRV_MAX_WORD, $urandom);
          gap_max = 6;
        end
        3: begin
          program_all(32'd0, 32'd0, rand_span(16), TGT_MIN_WORD, TGT_MAX_WORD,
                      -32'sd32767, 32'd32767, 32'h7FFF_FFFF);
          gap_max = 2;
        end
        4: begin
          program_all(rand_span(18), rand_span(8), rand_span(12), -32'sd1800, 32'd1800,
                      -32'sd500, 32'd500, 32'd50000);
          gap_max = 3;
        end
        default: begin
          program_all($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
          gap_max = 5;
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end
  endtask

  // The receiver holds off while beats keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    program_all(rand_span(18), rand_span(8), rand_span(12), TGT_MIN_WORD, TGT_MAX_WORD,
                DRV_MIN_WORD, DRV_MAX_WORD, WINDUP_WORD);
    gap_max = 0;
    hold_req = 300;
    send_beat(CMD_ACTIVATE, 1, 16'sd0, 16'sd0);
    repeat (20) random_item();
    wait_results_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_inactive_commands();
    test_update_timing_and_wrap();
    test_crossed_limits();
    test_rounding_and_gain_extremes();
    test_output_backpressure();
    test_random_settings();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (speed_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", speed_results_q.size()));
    $display("Covered %0d commands, %0d of them recomputing updates, under %0d settings.",
             items_accepted, recompute_count, settings_used);
    $display("Checked %0d results after %0d register writes; %0d mismatches.",
             results_checked, cfg_writes, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
